// ===== src/fsp_pkg.sv =====
// Shared types and constants for the float split packer.
package fsp_pkg;

    localparam int FLOAT_BIAS = 127;
    localparam int FRACTION_W = 23;
    localparam int MANT_OUT_W = 16;
    localparam int CFG_DATA_W = 8;
    localparam int CFG_IDX_W  = 1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EXP_WIDTH = 1'b0,
        CFG_EXP_BIAS  = 1'b1
    } cfg_idx_t;

    localparam logic [3:0] EXP_WIDTH_RESET = 4'd4;
    localparam logic [7:0] EXP_BIAS_RESET  = 8'd7;

    typedef struct packed {
        logic [31:0] float_bits;
        logic        final_item;
    } in_item_t;

    typedef struct packed {
        logic [15:0] mantissa_top;
        logic        mantissa_valid;
        logic [7:0]  sign_byte;
        logic        sign_byte_valid;
        logic [7:0]  exponent_byte;
        logic        exponent_byte_valid;
        logic        run_end;
    } out_item_t;

    // One classified item waiting for the output side
    typedef struct packed {
        logic [15:0] mant;
        logic        sb_valid;
        logic [7:0]  sb;
        logic        eb_valid;
        logic [7:0]  eb;
        logic        eb2_valid;
        logic [7:0]  eb2;
    } entry_t;

endpackage

// ===== src/float_split_packer.sv =====
// Top level of the float split packer: front end, item queue and back end.
// Splits float32 words into a truncated mantissa, packed sign bytes and an
// LSB-first bit-packed stream of rebiased exponents clamped to
// 0..2^exponent_width-1. One float is taken per clock while float_stall is
// low. Each item yields one result, except a final_item whose exponent flush
// needs a second byte: that one yields two results in turn, the second once
// the first is taken, and so holds the output side for both. An accepted
// item is written into the queue at the accept edge; the back end then loads
// it from the queue head into the output register. The queue of QUEUE_DEPTH
// items lets the front keep taking items while the output is stalled;
// float_stall rises only when that queue is full. Configuration writes
// (index 0: exponent width, saturated to 1..8; index 1: exponent bias) take
// effect at once and belong between streams while the block is idle.
module float_split_packer #(
    parameter int MANTISSA_KEEP = 16,
    parameter int QUEUE_DEPTH   = 4
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              float_valid,
    output logic                              float_stall,
    input  fsp_pkg::in_item_t                 float_item,
    output logic                              result_valid,
    input  logic                              result_stall,
    output fsp_pkg::out_item_t                result_item,
    input  logic                              cfg_write,
    input  logic [fsp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fsp_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int CntW = $clog2(QUEUE_DEPTH + 1);

    logic             push;
    logic             pop;
    fsp_pkg::entry_t  push_entry;
    fsp_pkg::entry_t  head;
    logic             q_full;
    logic             q_empty;
    logic [CntW-1:0]  q_count;

    assign float_stall = q_full;

    fsp_front #(
        .MANTISSA_KEEP (MANTISSA_KEEP)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .float_valid (float_valid),
        .float_item  (float_item),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .queue_full  (q_full),
        .push        (push),
        .push_entry  (push_entry)
    );

    fsp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .full       (q_full),
        .empty      (q_empty),
        .count      (q_count)
    );

    fsp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .empty        (q_empty),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_item  (result_item)
    );

    // A taken first result that is not the run end is followed by the
    // second flush result, which carries no mantissa.
    a_second_follows: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_stall && !result_item.run_end
        |=> result_valid && !result_item.mantissa_valid)
        else $error("flush second result missing");

    // A result without a mantissa is always a run-ending exponent byte.
    a_second_shape: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_item.mantissa_valid
        |-> result_item.run_end && result_item.exponent_byte_valid
            && !result_item.sign_byte_valid)
        else $error("malformed second result");

    // Queue only stalls the input when every slot is taken.
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        float_stall |-> q_count == CntW'(QUEUE_DEPTH))
        else $error("input stalled with free queue slots");

    // No pop from an empty queue.
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_empty)
        else $error("queue underflow");

endmodule

// ===== src/fsp_front.sv =====
// Front end: config registers, rebias/clamp and sign/exponent bit packing.
module fsp_front #(
    parameter int MANTISSA_KEEP = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              float_valid,
    input  fsp_pkg::in_item_t                 float_item,
    input  logic                              cfg_write,
    input  logic [fsp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fsp_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              queue_full,
    output logic                              push,
    output fsp_pkg::entry_t                   push_entry
);

    localparam int MantShift = fsp_pkg::FRACTION_W - MANTISSA_KEEP;

    logic [3:0]  exp_width_reg;
    logic [7:0]  exp_bias_reg;

    logic [7:0]  sign_acc_reg,  sign_acc_next;
    logic [2:0]  sign_cnt_reg,  sign_cnt_next;
    logic [7:0]  exp_acc_reg,   exp_acc_next;
    logic [2:0]  exp_off_reg,   exp_off_next;

    logic [3:0]  width_eff;
    logic [7:0]  emax;
    logic signed [9:0] exp_sum;
    logic [7:0]  exp_red;
    logic [22:0] mant_shifted;
    logic [7:0]  sign_merged;
    logic [15:0] exp_merged;
    logic [3:0]  off_sum;
    logic        exp_fill;
    logic [2:0]  off_after;
    logic [7:0]  acc_after;

    assign push = float_valid && !queue_full;

    // Width saturates to 1..8
    always_comb
    begin
        if (exp_width_reg == 4'd0)
            width_eff = 4'd1;
        else if (exp_width_reg > 4'd8)
            width_eff = 4'd8;
        else
            width_eff = exp_width_reg;
    end

    assign emax    = 8'hFF >> (4'd8 - width_eff);
    assign exp_sum = $signed({2'b00, float_item.float_bits[30:23]})
                   - 10'sd127 + $signed({2'b00, exp_bias_reg});

    always_comb
    begin
        priority if (exp_sum < 10'sd0)
            exp_red = 8'd0;
        else if (exp_sum > $signed({2'b00, emax}))
            exp_red = emax;
        else
            exp_red = exp_sum[7:0];
    end

    assign mant_shifted = float_item.float_bits[22:0] >> MantShift;
    assign sign_merged  = sign_acc_reg | (8'(float_item.float_bits[31]) << sign_cnt_reg);
    assign exp_merged   = {8'd0, exp_acc_reg} | ({8'd0, exp_red} << exp_off_reg);
    assign off_sum      = {1'b0, exp_off_reg} + width_eff;
    assign exp_fill     = off_sum >= 4'd8;
    assign off_after    = off_sum[2:0];
    assign acc_after    = exp_fill ? exp_merged[15:8] : exp_merged[7:0];

    always_comb
    begin
        push_entry      = '0;
        push_entry.mant = (exp_red != 8'd0) ? mant_shifted[15:0] : 16'd0;

        // sign bits
        sign_acc_next = sign_acc_reg;
        sign_cnt_next = sign_cnt_reg;
        if (push)
        begin
            if (sign_cnt_reg == 3'd7 || float_item.final_item)
            begin
                push_entry.sb_valid = 1'b1;
                push_entry.sb       = sign_merged;
                sign_acc_next       = 8'd0;
                sign_cnt_next       = 3'd0;
            end
            else
            begin
                sign_acc_next = sign_merged;
                sign_cnt_next = sign_cnt_reg + 3'd1;
            end
        end

        // exponent stream
        exp_acc_next = exp_acc_reg;
        exp_off_next = exp_off_reg;
        if (exp_fill)
        begin
            push_entry.eb_valid = 1'b1;
            push_entry.eb       = exp_merged[7:0];
        end
        if (push)
        begin
            exp_acc_next = acc_after;
            exp_off_next = off_after;
            if (float_item.final_item && off_after != 3'd0)
            begin
                if (exp_fill)
                begin
                    push_entry.eb2_valid = 1'b1;
                    push_entry.eb2       = acc_after;
                end
                else
                begin
                    push_entry.eb_valid = 1'b1;
                    push_entry.eb       = acc_after;
                end
                exp_acc_next = 8'd0;
                exp_off_next = 3'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_width_reg <= fsp_pkg::EXP_WIDTH_RESET;
            exp_bias_reg  <= fsp_pkg::EXP_BIAS_RESET;
            sign_acc_reg  <= 8'd0;
            sign_cnt_reg  <= 3'd0;
            exp_acc_reg   <= 8'd0;
            exp_off_reg   <= 3'd0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (fsp_pkg::cfg_idx_t'(cfg_index))
                    fsp_pkg::CFG_EXP_WIDTH: exp_width_reg <= cfg_data[3:0];
                    fsp_pkg::CFG_EXP_BIAS:  exp_bias_reg  <= cfg_data;
                    default: ;
                endcase
            end
            sign_acc_reg <= sign_acc_next;
            sign_cnt_reg <= sign_cnt_next;
            exp_acc_reg  <= exp_acc_next;
            exp_off_reg  <= exp_off_next;
        end
    end

endmodule

// ===== src/fsp_queue.sv =====
// Small FIFO of classified items between the front and back ends.
module fsp_queue #(
    parameter int DEPTH = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  fsp_pkg::entry_t               push_entry,
    input  logic                          pop,
    output fsp_pkg::entry_t               head,
    output logic                          full,
    output logic                          empty,
    output logic [$clog2(DEPTH+1)-1:0]    count
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    fsp_pkg::entry_t entries_reg [DEPTH];
    logic [PtrW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CntW-1:0] count_reg;

    function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
        logic [PtrW-1:0] r;
        if (p == PtrW'(DEPTH - 1))
            r = '0;
        else
            r = p + PtrW'(1);
        return r;
    endfunction

    assign head  = entries_reg[rd_ptr_reg];
    assign full  = count_reg == CntW'(DEPTH);
    assign empty = count_reg == '0;
    assign count = count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
            entries_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (pop)
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + CntW'(1);
                2'b01:   count_reg <= count_reg - CntW'(1);
                default: ;
            endcase
        end
    end

endmodule

// ===== src/fsp_back.sv =====
// Back end: turns queued items into one or two results in an output register.
module fsp_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  fsp_pkg::entry_t      head,
    input  logic                 empty,
    output logic                 pop,
    output logic                 result_valid,
    input  logic                 result_stall,
    output fsp_pkg::out_item_t   result_item
);

    logic                 out_valid_reg, out_valid_next;
    logic                 second_reg,    second_next;
    fsp_pkg::out_item_t   out_data_reg,  out_data_next;
    logic                 load;

    assign load         = !out_valid_reg || !result_stall;
    assign result_valid = out_valid_reg;
    assign result_item  = out_data_reg;

    always_comb
    begin
        pop            = 1'b0;
        second_next    = second_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (load)
        begin
            out_valid_next = !empty;
            if (!empty)
            begin
                out_data_next = '0;
                if (!second_reg)
                begin
                    out_data_next.mantissa_top        = head.mant;
                    out_data_next.mantissa_valid      = 1'b1;
                    out_data_next.sign_byte           = head.sb;
                    out_data_next.sign_byte_valid     = head.sb_valid;
                    out_data_next.exponent_byte       = head.eb;
                    out_data_next.exponent_byte_valid = head.eb_valid;
                    out_data_next.run_end             = !head.eb2_valid;
                    if (head.eb2_valid)
                        second_next = 1'b1;
                    else
                        pop = 1'b1;
                end
                else
                begin
                    out_data_next.exponent_byte       = head.eb2;
                    out_data_next.exponent_byte_valid = 1'b1;
                    out_data_next.run_end             = 1'b1;
                    second_next                       = 1'b0;
                    pop                               = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            second_reg    <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            second_reg    <= second_next;
        end
    end

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for float_split_packer: directed and random floats against a model.
module testbench;

    // Upper mantissa bits kept by the block at its default parameter
    localparam int KEEP = 16;

    logic                           clk;
    logic                           rst_n;
    logic                           float_valid;
    logic                           float_stall;
    fsp_pkg::in_item_t              float_item;
    logic                           result_valid;
    logic                           result_stall;
    fsp_pkg::out_item_t             result_item;
    logic                           cfg_write;
    logic [fsp_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [fsp_pkg::CFG_DATA_W-1:0] cfg_data;

    float_split_packer u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .float_valid  (float_valid),
        .float_stall  (float_stall),
        .float_item   (float_item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_item  (result_item),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Mirror of the configuration registers, updated at the write edge
    logic [3:0] width_reg = fsp_pkg::EXP_WIDTH_RESET;
    logic [7:0] bias_reg  = fsp_pkg::EXP_BIAS_RESET;

    // Mirror of the packer state
    logic [7:0] sign_acc  = '0;
    logic [2:0] sign_cnt  = '0;
    logic [7:0] exp_acc   = '0;
    logic [2:0] exp_off   = '0;

    // Results the block still owes, oldest first
    fsp_pkg::out_item_t  pending_results[$];

    int mismatches        = 0;
    int send_idle_pct     = 0;
    int recv_stall_pct    = 0;
    int stall_hold_cycles = 0;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Generous upper bound: even the slowest legal run ends well inside this.
    initial
    begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // Width register saturates: 0 behaves as 1, anything above 8 as 8.
    function automatic int eff_width();
        int w;
        w = int'(width_reg);
        if (w < 1) w = 1;
        if (w > 8) w = 8;
        return w;
    endfunction

    // Works out the one or two results that an accepted float causes and
    // advances the mirrored packer state.
    task automatic split_float(input fsp_pkg::in_item_t it);
        int        w;
        int        e;
        int        emax;
        int        off_sum;
        logic [7:0]  eu;
        logic [15:0] shifted;
        fsp_pkg::out_item_t r0;
        fsp_pkg::out_item_t r1;
        logic      two;
        w    = eff_width();
        emax = (1 << w) - 1;
        e    = int'(it.float_bits[30:23]) - fsp_pkg::FLOAT_BIAS + int'(bias_reg);
        if (e < 0) e = 0;
        if (e > emax) e = emax;
        eu   = e[7:0];
        r0   = '0;
        r1   = '0;
        two  = 1'b0;

        // Mantissa is dropped when the reduced exponent clamps to zero
        r0.mantissa_top   = (eu != 0) ? it.float_bits[22 -: KEEP] : '0;
        r0.mantissa_valid = 1'b1;

        // Sign bits, LSB first; a final item flushes a partial byte
        sign_acc = sign_acc | (8'(it.float_bits[31]) << sign_cnt);
        if (sign_cnt == 3'd7 || it.final_item)
        begin
            r0.sign_byte       = sign_acc;
            r0.sign_byte_valid = 1'b1;
            sign_acc = '0;
            sign_cnt = '0;
        end
        else
        begin
            sign_cnt = sign_cnt + 3'd1;
        end

        // Exponent bit stream; the spill above bit 7 starts the next byte
        shifted = 16'(eu) << exp_off;
        off_sum = int'(exp_off) + w;
        if (off_sum >= 8)
        begin
            r0.exponent_byte       = exp_acc | shifted[7:0];
            r0.exponent_byte_valid = 1'b1;
            exp_acc = shifted[15:8];
            exp_off = 3'(off_sum - 8);
        end
        else
        begin
            exp_acc = exp_acc | shifted[7:0];
            exp_off = 3'(off_sum);
        end

        // Flush of leftover exponent bits; needs a second result when this
        // item already filled a byte
        if (it.final_item && exp_off != 0)
        begin
            if (r0.exponent_byte_valid)
            begin
                two = 1'b1;
                r1.exponent_byte       = exp_acc;
                r1.exponent_byte_valid = 1'b1;
            end
            else
            begin
                r0.exponent_byte       = exp_acc;
                r0.exponent_byte_valid = 1'b1;
            end
            exp_acc = '0;
            exp_off = '0;
        end

        r0.run_end = !two;
        pending_results.push_back(r0);
        if (two)
        begin
            r1.run_end = 1'b1;
            pending_results.push_back(r1);
        end
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    // Monitor: checks results, then predicts from accepted floats and
    // tracks register writes. All sampled at the rising edge.
    always @(posedge clk)
    begin : monitor
        fsp_pkg::out_item_t want;
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result with none expected: %h", result_item);
                    mismatches++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("mantissa_top", want.mantissa_top,
                                result_item.mantissa_top);
                    check_field("mantissa_valid", want.mantissa_valid,
                                result_item.mantissa_valid);
                    check_field("sign_byte", want.sign_byte, result_item.sign_byte);
                    check_field("sign_byte_valid", want.sign_byte_valid,
                                result_item.sign_byte_valid);
                    check_field("exponent_byte", want.exponent_byte,
                                result_item.exponent_byte);
                    check_field("exponent_byte_valid", want.exponent_byte_valid,
                                result_item.exponent_byte_valid);
                    check_field("run_end", want.run_end, result_item.run_end);
                end
            end
            if (float_valid && !float_stall)
                split_float(float_item);
            if (cfg_write)
            begin
                if (cfg_index == fsp_pkg::CFG_EXP_WIDTH)
                    width_reg = cfg_data[3:0];
                else if (cfg_index == fsp_pkg::CFG_EXP_BIAS)
                    bias_reg = cfg_data;
            end
        end
    end

    // Receiver: random stalls, or a counted hold-off when one is requested
    always @(negedge clk)
    begin
        if (stall_hold_cycles > 0)
        begin
            result_stall <= 1'b1;
            stall_hold_cycles--;
        end
        else
        begin
            result_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Offers one float, with random idle cycles first, and returns at the
    // edge where it is taken.
    task automatic send_float(input logic [31:0] bits, input logic last);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            float_valid <= 1'b0;
            @(negedge clk);
        end
        float_valid <= 1'b1;
        float_item  <= '{float_bits: bits, final_item: last};
        @(posedge clk);
        while (float_stall)
            @(posedge clk);
    endtask

    // Stops offering and waits until every owed result has come out, then
    // lets anything still in flight settle.
    task automatic wait_idle();
        @(negedge clk);
        float_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input fsp_pkg::cfg_idx_t idx, input logic [7:0] value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // Random float whose exponent mostly lands near the clamp limits of the
    // current format, so both clamps and the in-range band get hit.
    function automatic logic [31:0] pick_float();
        int          top;
        int          e;
        logic [31:0] f;
        f = $urandom();
        if ($urandom_range(3) != 0)
        begin
            top = (1 << eff_width()) - 1;
            e = int'($urandom_range(top + 4)) - 2 + fsp_pkg::FLOAT_BIAS - int'(bias_reg);
            if (e < 0) e = 0;
            if (e > 255) e = 255;
            f[30:23] = e[7:0];
        end
        return f;
    endfunction

    // Reset format: zero, all ones, an infinity, both clamps; the eighth item
    // is final with a full sign byte, the ninth flushes a single sign bit.
    task automatic test_reset_format();
        send_float(32'h0000_0000, 1'b0);
        send_float(32'hFFFF_FFFF, 1'b0);
        send_float(32'h8000_0000, 1'b0);
        send_float(32'h7F80_0000, 1'b0);
        send_float(32'h3F80_0000, 1'b0);
        send_float(32'h7F7F_FFFF, 1'b0);
        send_float(32'h3C00_0000, 1'b0);   // rebiased exponent exactly 0
        send_float(32'hBB80_0000, 1'b1);   // below range, clamps to 0
        send_float(32'hC400_0000, 1'b1);   // above range, clamps to max
        wait_idle();
    endtask

    // Width 3: the third item fills a byte and leaves one bit, so the flush
    // needs a second result.
    task automatic test_double_flush();
        write_reg(fsp_pkg::CFG_EXP_WIDTH, 8'd3);
        write_reg(fsp_pkg::CFG_EXP_BIAS, 8'd0);
        send_float(32'h4300_0001, 1'b0);
        send_float(32'hC0FF_FFFF, 1'b0);
        send_float(32'h4080_8000, 1'b1);
        wait_idle();
    endtask

    // Width 0 behaves as 1; then width 15 (as 8) is set mid-stream, and
    // packing carries on from the current bit offset.
    task automatic test_width_limits();
        write_reg(fsp_pkg::CFG_EXP_WIDTH, 8'd0);
        write_reg(fsp_pkg::CFG_EXP_BIAS, 8'd255);
        send_float(32'h0000_0000, 1'b0);
        send_float(32'hFF80_0000, 1'b0);
        wait_idle();
        write_reg(fsp_pkg::CFG_EXP_WIDTH, 8'd15);
        send_float(32'h807F_FFFF, 1'b1);
        wait_idle();
    endtask

    // Receiver holds off while the sender keeps offering, so the queue in
    // the block fills and its input stalls.
    task automatic test_backpressure();
        write_reg(fsp_pkg::CFG_EXP_WIDTH, 8'd5);
        write_reg(fsp_pkg::CFG_EXP_BIAS, 8'd100);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        stall_hold_cycles = 40;
        for (int i = 0; i < 24; i++)
            send_float(pick_float(), i == 23 || i % 7 == 6);
        wait_idle();
    endtask

    // Random phases: each picks a format (often an extreme one) while idle,
    // then sends streams of random floats. A phase may end mid-stream, so
    // the next format applies from the current bit offset.
    task automatic test_random(input int item_total, input int snd_pct,
                               input int rcv_pct);
        int sent;
        int phase_len;
        sent = 0;
        send_idle_pct  = snd_pct;
        recv_stall_pct = rcv_pct;
        while (sent < item_total)
        begin
            if ($urandom_range(2) == 0)
            begin
                case ($urandom_range(3))
                    0: write_reg(fsp_pkg::CFG_EXP_WIDTH, 8'd0);
                    1: write_reg(fsp_pkg::CFG_EXP_WIDTH, 8'd1);
                    2: write_reg(fsp_pkg::CFG_EXP_WIDTH, 8'd8);
                    default: write_reg(fsp_pkg::CFG_EXP_WIDTH, 8'd15);
                endcase
                write_reg(fsp_pkg::CFG_EXP_BIAS, $urandom_range(1) ? 8'd255 : 8'd0);
            end
            else
            begin
                write_reg(fsp_pkg::CFG_EXP_WIDTH, 8'($urandom_range(15)));
                write_reg(fsp_pkg::CFG_EXP_BIAS, 8'($urandom_range(255)));
            end
            phase_len = $urandom_range(10, 60);
            for (int i = 0; i < phase_len; i++)
                send_float(pick_float(), $urandom_range(11) == 0);
            sent += phase_len;
            wait_idle();
        end
    endtask

    initial
    begin
        // Every input known from time zero; reset held low, then released at a falling edge
        rst_n       = 1'b0;
        float_valid = 1'b0;
        float_item  = '0;
        cfg_write   = 1'b0;
        cfg_index   = fsp_pkg::CFG_EXP_WIDTH;
        cfg_data    = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_format();
        test_double_flush();
        test_width_limits();
        test_backpressure();
        test_random(380, 35, 49);
        test_random(380, 49, 35);
        test_random(390, 0, 0);

        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
